### rtl/ssefs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssefs_pkg
// Shared types and constants for the SSE frame splitter.
// ----------------------------------------------------------------------------
package ssefs_pkg;

    localparam int MAX_W                   = 24;
    localparam int FRAME_COUNT_BITS_DEF    = 25;
    localparam int OP_QUEUE_DEPTH_DEF      = 4;
    localparam logic [MAX_W-1:0] MAX_FRAME_RESET = 24'd1048576;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_FLUSH,
        OP_BOM_ERR
    } op_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_TOO_LARGE,
        ERR_BOM_REPEAT
    } err_code_t;

    typedef enum logic [1:0] {
        BOM_FIRST,
        BOM_SECOND,
        BOM_PASS
    } bom_phase_t;

    typedef enum logic {
        FS_IDLE,
        FS_RELEASE
    } front_state_t;

    // one queued operation for the back end; eoi marks the last op of a word
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       eoi;
    } op_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       line_end;
        logic       frame_end;
        logic       stream_end;
        logic       incomplete;
        err_code_t  error_code;
    } res_t;

    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBB;
            default: b = 8'hBF;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/sse_frame_splitter_unit.sv
`default_nettype none
// Path: an accepted word is pushed into the op queue; the line engine takes
// its ops into the hold stage, which passes each result word on to the output
// register. Throughput: one word per cycle while the op queue has room and
// m_ready does not stall; replaying a held partial BOM stalls the input while
// held bytes are queued, and a lone CR or CRLF holds an op for its second word.
// Reset: synchronous, active low; clears all stream state, frame limit = 1048576.
// ----------------------------------------------------------------------------
// sse_frame_splitter_unit
// Tags a Server-Sent Events byte stream with line, frame and stream markers.
// ----------------------------------------------------------------------------
module sse_frame_splitter_unit
    import ssefs_pkg::*;
#(
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF,
    parameter int OP_QUEUE_DEPTH   = OP_QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [MAX_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_cmd,
    input  wire logic [7:0]       s_data_byte,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_byte_valid,
    output logic                  m_line_end,
    output logic                  m_frame_end,
    output logic                  m_stream_end,
    output logic                  m_incomplete,
    output logic [1:0]            m_error_code,
    output logic                  m_last
);

    logic [MAX_W-1:0] max_frame_reg;
    logic             q_full;
    logic             q_push;
    op_t              q_op;
    logic             q_pop;
    op_t              head_op;
    logic             head_valid;
    res_t             m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= MAX_FRAME_RESET;
        end else if (cfg_wr_en) begin
            max_frame_reg <= cfg_wr_data;
        end
    end

    ssefs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (q_op)
    );

    ssefs_op_fifo #(
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_op    (head_op),
        .head_valid (head_valid)
    );

    ssefs_back #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .frame_limit     (max_frame_reg),
        .op_valid        (head_valid),
        .op              (head_op),
        .op_pop          (q_pop),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_res           (m_res),
        .m_last          (m_last)
    );

    assign m_out_byte   = m_res.out_byte;
    assign m_byte_valid = m_res.byte_valid;
    assign m_line_end   = m_res.line_end;
    assign m_frame_end  = m_res.frame_end;
    assign m_stream_end = m_res.stream_end;
    assign m_incomplete = m_res.incomplete;
    assign m_error_code = m_res.error_code;

endmodule
`default_nettype wire

### rtl/ssefs_op_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssefs_op_fifo
// Small flop-based queue of operations between front and back end.
// ----------------------------------------------------------------------------
module ssefs_op_fifo
    import ssefs_pkg::*;
#(
    parameter int DEPTH = OP_QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire op_t  push_op,
    output logic      full,
    input  wire logic pop,
    output op_t       head_op,
    output logic      head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_op    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_ONE;
            2'b01:   count_next = count_reg - CNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

### rtl/ssefs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssefs_front
// Input side: leading BOM detection and stripping, repeated-BOM error op, turns words into ops.
// ----------------------------------------------------------------------------
module ssefs_front
    import ssefs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_cmd,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output op_t             q_op
);

    front_state_t fs_reg, fs_next;
    bom_phase_t   bom_phase_reg, bom_phase_next;
    logic [1:0]   bom_matched_reg, bom_matched_next;
    logic [1:0]   rel_idx_reg, rel_idx_next;
    logic [1:0]   rel_len_reg, rel_len_next;
    logic         held_cmd_reg;
    logic [7:0]   held_byte_reg;

    logic accept;
    logic in_bom;
    logic bom_hit;
    logic need_rel;
    logic rel_more;

    assign s_ready  = (fs_reg == FS_IDLE) && !q_full;
    assign accept   = s_valid && s_ready;
    assign in_bom   = bom_phase_reg != BOM_PASS;
    assign bom_hit  = s_data_byte == bom_byte(bom_matched_reg);
    // held prefix must be replayed as stream bytes
    assign need_rel = in_bom && (bom_matched_reg != 2'd0) && (s_cmd || !bom_hit);
    assign rel_more = rel_idx_reg < rel_len_reg;

    // next state
    always_comb begin
        fs_next          = fs_reg;
        bom_phase_next   = bom_phase_reg;
        bom_matched_next = bom_matched_reg;
        rel_idx_next     = rel_idx_reg;
        rel_len_next     = rel_len_reg;
        case (fs_reg)
            FS_IDLE: begin
                if (accept) begin
                    if (need_rel) begin
                        fs_next      = FS_RELEASE;
                        rel_idx_next = 2'd1;
                        rel_len_next = bom_matched_reg;
                    end
                    if (s_cmd) begin
                        bom_phase_next   = BOM_FIRST;
                        bom_matched_next = 2'd0;
                    end else if (in_bom) begin
                        if (bom_hit) begin
                            if (bom_matched_reg == 2'd2) begin
                                bom_matched_next = 2'd0;
                                bom_phase_next   = (bom_phase_reg == BOM_FIRST) ?
                                                   BOM_SECOND : BOM_PASS;
                            end else begin
                                bom_matched_next = bom_matched_reg + 2'd1;
                            end
                        end else begin
                            bom_matched_next = 2'd0;
                            bom_phase_next   = BOM_PASS;
                        end
                    end
                end
            end
            FS_RELEASE: begin
                if (!q_full) begin
                    if (rel_more) begin
                        rel_idx_next = rel_idx_reg + 2'd1;
                    end else begin
                        fs_next = FS_IDLE;
                    end
                end
            end
            default: fs_next = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_push      = 1'b0;
        q_op.kind   = OP_BYTE;
        q_op.data   = s_data_byte;
        q_op.eoi    = 1'b1;
        case (fs_reg)
            FS_IDLE: begin
                if (accept) begin
                    if (need_rel) begin
                        q_push    = 1'b1;
                        q_op.data = bom_byte(2'd0);
                        q_op.eoi  = 1'b0;
                    end else if (s_cmd) begin
                        q_push    = 1'b1;
                        q_op.kind = OP_FLUSH;
                        q_op.data = 8'h00;
                    end else if (!in_bom || !bom_hit) begin
                        q_push    = 1'b1;
                    end else if (bom_matched_reg == 2'd2 && bom_phase_reg == BOM_SECOND) begin
                        q_push    = 1'b1;
                        q_op.kind = OP_BOM_ERR;
                        q_op.data = 8'h00;
                    end
                end
            end
            FS_RELEASE: begin
                if (!q_full) begin
                    q_push = 1'b1;
                    if (rel_more) begin
                        q_op.data = bom_byte(rel_idx_reg);
                        q_op.eoi  = 1'b0;
                    end else begin
                        q_op.kind = held_cmd_reg ? OP_FLUSH : OP_BYTE;
                        q_op.data = held_cmd_reg ? 8'h00 : held_byte_reg;
                    end
                end
            end
            default: q_push = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg          <= FS_IDLE;
            bom_phase_reg   <= BOM_FIRST;
            bom_matched_reg <= 2'd0;
            rel_idx_reg     <= 2'd0;
            rel_len_reg     <= 2'd0;
        end else begin
            fs_reg          <= fs_next;
            bom_phase_reg   <= bom_phase_next;
            bom_matched_reg <= bom_matched_next;
            rel_idx_reg     <= rel_idx_next;
            rel_len_reg     <= rel_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && need_rel) begin
            held_cmd_reg  <= s_cmd;
            held_byte_reg <= s_data_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("op pushed into full queue");

    a_release_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (fs_reg == FS_RELEASE) |-> (rel_len_reg != 2'd0) && (rel_idx_reg <= rel_len_reg))
        else $error("BOM release index out of range");

    a_prefix_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (bom_matched_reg != 2'd0) |-> (bom_phase_reg != BOM_PASS))
        else $error("BOM prefix held in pass-through phase");
`endif

endmodule
`default_nettype wire

### rtl/ssefs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssefs_back
// Line/frame engine: CR/LF handling, frame length check, error latch,
// last-word resolution and output register.
// ----------------------------------------------------------------------------
module ssefs_back
    import ssefs_pkg::*;
#(
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [MAX_W-1:0] frame_limit,
    input  wire logic             op_valid,
    input  wire op_t              op,
    output logic                  op_pop,
    input  wire logic             m_ready,
    output logic                  m_valid,
    output res_t                  m_res,
    output logic                  m_last
);

    localparam int CMP_W = (FRAME_COUNT_BITS > MAX_W) ? FRAME_COUNT_BITS : MAX_W;
    localparam logic [FRAME_COUNT_BITS-1:0] FC_ONE = FRAME_COUNT_BITS'(1);
    localparam logic [FRAME_COUNT_BITS-1:0] FC_MAX = '1;

    logic                        cr_reg, cr_next;
    logic                        le_reg, le_next;
    logic [FRAME_COUNT_BITS-1:0] fc_reg, fc_next;
    logic                        failed_reg, failed_next;
    logic                        skip_reg, skip_next;

    // hold stage: result whose last flag is not yet known
    logic h_valid_reg, h_valid_next;
    logic h_closed_reg, h_closed_next;
    res_t h_res_reg, h_res_next;

    logic m_valid_reg, m_valid_next;
    res_t m_res_reg;
    logic m_last_reg;

    logic                        out_free;
    logic                        go;
    logic [FRAME_COUNT_BITS-1:0] cnt_inc;
    logic                        over;
    logic                        cand;
    res_t                        cand_res;
    logic                        close;
    logic                        emit_h;

    assign out_free = !m_valid_reg || m_ready;
    assign go       = op_valid && out_free;
    assign cnt_inc  = (fc_reg == FC_MAX) ? fc_reg : fc_reg + FC_ONE;
    assign over     = CMP_W'(cnt_inc) > CMP_W'(frame_limit);

    always_comb begin
        cr_next     = cr_reg;
        le_next     = le_reg;
        fc_next     = fc_reg;
        failed_next = failed_reg;
        skip_next   = skip_reg;
        op_pop      = 1'b0;
        cand        = 1'b0;
        cand_res    = '0;
        if (go) begin
            case (op.kind)
                OP_BYTE: begin
                    if (failed_reg) begin
                        op_pop = 1'b1;
                    end else if (cr_reg && op.data != CH_LF) begin
                        // lone CR ends the line, op stays at the queue head to be replayed
                        cand                = 1'b1;
                        cand_res.out_byte   = CH_CR;
                        cand_res.byte_valid = 1'b1;
                        cand_res.line_end   = 1'b1;
                        cand_res.frame_end  = le_reg;
                        if (le_reg) fc_next = '0;
                        le_next             = 1'b1;
                        cr_next             = 1'b0;
                    end else if (skip_reg) begin
                        // LF half of CRLF, already counted
                        cand                = 1'b1;
                        cand_res.out_byte   = CH_LF;
                        cand_res.byte_valid = 1'b1;
                        cand_res.line_end   = 1'b1;
                        cand_res.frame_end  = le_reg;
                        if (le_reg) fc_next = '0;
                        le_next             = 1'b1;
                        skip_next           = 1'b0;
                        op_pop              = 1'b1;
                    end else if (over) begin
                        cand                = 1'b1;
                        cand_res.error_code = ERR_TOO_LARGE;
                        failed_next         = 1'b1;
                        cr_next             = 1'b0;
                        fc_next             = cnt_inc;
                        op_pop              = 1'b1;
                    end else begin
                        fc_next = cnt_inc;
                        if (cr_reg) begin
                            cand                = 1'b1;
                            cand_res.out_byte   = CH_CR;
                            cand_res.byte_valid = 1'b1;
                            cr_next             = 1'b0;
                            skip_next           = 1'b1;
                        end else if (op.data == CH_CR) begin
                            cr_next = 1'b1;
                            op_pop  = 1'b1;
                        end else if (op.data == CH_LF) begin
                            cand                = 1'b1;
                            cand_res.out_byte   = CH_LF;
                            cand_res.byte_valid = 1'b1;
                            cand_res.line_end   = 1'b1;
                            cand_res.frame_end  = le_reg;
                            if (le_reg) fc_next = '0;
                            le_next             = 1'b1;
                            op_pop              = 1'b1;
                        end else begin
                            cand                = 1'b1;
                            cand_res.out_byte   = op.data;
                            cand_res.byte_valid = 1'b1;
                            le_next             = 1'b0;
                            op_pop              = 1'b1;
                        end
                    end
                end
                OP_FLUSH: begin
                    if (!failed_reg && cr_reg) begin
                        cand                = 1'b1;
                        cand_res.out_byte   = CH_CR;
                        cand_res.byte_valid = 1'b1;
                        cand_res.line_end   = 1'b1;
                        cand_res.frame_end  = le_reg;
                        if (le_reg) fc_next = '0;
                        le_next             = 1'b1;
                        cr_next             = 1'b0;
                    end else begin
                        cand                = 1'b1;
                        cand_res.stream_end = 1'b1;
                        cand_res.incomplete = !failed_reg && (fc_reg != '0);
                        cr_next             = 1'b0;
                        le_next             = 1'b1;
                        fc_next             = '0;
                        failed_next         = 1'b0;
                        skip_next           = 1'b0;
                        op_pop              = 1'b1;
                    end
                end
                OP_BOM_ERR: begin
                    if (!failed_reg) begin
                        cand                = 1'b1;
                        cand_res.error_code = ERR_BOM_REPEAT;
                        failed_next         = 1'b1;
                    end
                    op_pop = 1'b1;
                end
                default: op_pop = 1'b1;
            endcase
        end
    end

    assign close  = op_pop && op.eoi;
    assign emit_h = out_free && h_valid_reg && (h_closed_reg || cand);

    always_comb begin
        h_valid_next  = h_valid_reg;
        h_closed_next = h_closed_reg;
        h_res_next    = h_res_reg;
        if (cand) begin
            h_valid_next  = 1'b1;
            h_closed_next = close;
            h_res_next    = cand_res;
        end else if (emit_h) begin
            h_valid_next  = 1'b0;
            h_closed_next = 1'b0;
        end else if (close && h_valid_reg) begin
            h_closed_next = 1'b1;
        end

        if (emit_h) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_reg       <= 1'b0;
            le_reg       <= 1'b1;
            fc_reg       <= '0;
            failed_reg   <= 1'b0;
            skip_reg     <= 1'b0;
            h_valid_reg  <= 1'b0;
            h_closed_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cr_reg       <= cr_next;
            le_reg       <= le_next;
            fc_reg       <= fc_next;
            failed_reg   <= failed_next;
            skip_reg     <= skip_next;
            h_valid_reg  <= h_valid_next;
            h_closed_reg <= h_closed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_res_reg <= h_res_next;
        if (emit_h) begin
            m_res_reg  <= h_res_reg;
            m_last_reg <= h_closed_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_closed_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        h_closed_reg |-> h_valid_reg)
        else $error("closed hold entry without valid");

    a_skip_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> op_valid && (op.kind == OP_BYTE) && (op.data == CH_LF) && !cr_reg)
        else $error("CRLF second half without LF at queue head");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.stream_end) |-> m_last_reg)
        else $error("stream end word not marked last");

    a_err_nobyte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_res_reg.error_code != ERR_NONE)) |-> !m_res_reg.byte_valid)
        else $error("error word carries a byte");
`endif

endmodule
`default_nettype wire
